@@ hdl/ems_pkg.sv @@
package ems_pkg;

  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  localparam int EXT_BITS     = 2 * WORD_BITS;
  localparam int UWORD_BITS   = WORD_BITS - 1;
  localparam int MAX_SPRINGS  = 8;
  localparam int IDX_BITS     = 3;
  localparam int COUNT_BITS   = 4;
  localparam int CFG_IDX_BITS = 3;
  localparam int RAD_BITS     = EXT_BITS;
  localparam int NUM_BITS     = UWORD_BITS + FRAC_BITS;

  localparam logic signed [EXT_BITS-1:0] WORD_MAX =
    {{(EXT_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [EXT_BITS-1:0] WORD_MIN = ~WORD_MAX;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SET  = 2'd1,
    OP_STEP = 2'd2
  } opcode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SPRING_COUNT = 3'd0,
    CFG_DAMPING      = 3'd1,
    CFG_GRAVITY      = 3'd2,
    CFG_TIME_STEP    = 3'd3
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD,
    ST_DIFF,
    ST_SQ_MUL,
    ST_SQ_ADD,
    ST_SQRT_START,
    ST_SQRT_WAIT,
    ST_LEN_CHECK,
    ST_DIV_WAIT,
    ST_FCALC,
    ST_TMUL,
    ST_TSAT,
    ST_FMUL,
    ST_ACC,
    ST_NEXT,
    ST_DAMP_MUL,
    ST_DAMP_ACC,
    ST_GRAV,
    ST_POS_MUL,
    ST_POS_ACC,
    ST_VEL_MUL,
    ST_VEL_ACC,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]                  opcode;
    logic [IDX_BITS-1:0]         spring_index;
    logic signed [WORD_BITS-1:0] vec_a_x;
    logic signed [WORD_BITS-1:0] vec_a_y;
    logic signed [WORD_BITS-1:0] vec_a_z;
    logic signed [WORD_BITS-1:0] vec_b_x;
    logic signed [WORD_BITS-1:0] vec_b_y;
    logic signed [WORD_BITS-1:0] vec_b_z;
    logic [UWORD_BITS-1:0]       rest_length;
    logic [UWORD_BITS-1:0]       stiffness;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] pos_x;
    logic signed [WORD_BITS-1:0] pos_y;
    logic signed [WORD_BITS-1:0] pos_z;
    logic signed [WORD_BITS-1:0] vel_x;
    logic signed [WORD_BITS-1:0] vel_y;
    logic signed [WORD_BITS-1:0] vel_z;
    logic                        degenerate;
    logic                        saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] anchor_x;
    logic signed [WORD_BITS-1:0] anchor_y;
    logic signed [WORD_BITS-1:0] anchor_z;
    logic [UWORD_BITS-1:0]       rest_length;
    logic [UWORD_BITS-1:0]       stiffness;
  } spring_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] val;
    logic                        clip;
  } sat_t;

  function automatic logic signed [EXT_BITS-1:0] sext_word(
    input logic signed [WORD_BITS-1:0] a
  );
    return {{(EXT_BITS-WORD_BITS){a[WORD_BITS-1]}}, a};
  endfunction

  function automatic sat_t sat_word(input logic signed [EXT_BITS-1:0] v);
    sat_t r;
    if (v > WORD_MAX) begin
      r.val  = WORD_MAX[WORD_BITS-1:0];
      r.clip = 1'b1;
    end else if (v < WORD_MIN) begin
      r.val  = WORD_MIN[WORD_BITS-1:0];
      r.clip = 1'b1;
    end else begin
      r.val  = v[WORD_BITS-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ hdl/ems_ram.sv @@
module ems_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/ems_isqrt.sv @@
module ems_isqrt #(
  parameter int RAD_BITS = ems_pkg::RAD_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [RAD_BITS-1:0]   rad_i,
  output logic                  busy_o,
  output logic [RAD_BITS/2-1:0] root_o
);

  localparam int H     = RAD_BITS / 2;
  localparam int CNT_W = $clog2(H);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RAD_BITS-1:0] rad_q;
  logic [H:0]       rem_q;
  logic [H-1:0]     root_q;
  logic [H+2:0]     rem_sh;
  logic [H+2:0]     trial;
  logic [H+2:0]     diff;
  logic             ge;

  // two radicand bits enter per step, one root bit leaves
  assign rem_sh = {rem_q, rad_q[RAD_BITS-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(H - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? diff[H:0] : rem_sh[H:0];
      root_q <= {root_q[H-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

@@ hdl/ems_div.sv @@
module ems_div #(
  parameter int NUM_BITS = ems_pkg::NUM_BITS,
  parameter int DEN_BITS = ems_pkg::WORD_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_BITS-1:0] num_i,
  input  logic [DEN_BITS-1:0] den_i,
  output logic                busy_o,
  output logic [NUM_BITS-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_BITS);

  logic                busy_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [NUM_BITS-1:0] q_q;
  logic [DEN_BITS-1:0] rem_q;
  logic [DEN_BITS-1:0] den_q;
  logic [DEN_BITS:0]   rem_sh;
  logic [DEN_BITS:0]   diff;
  logic                ge;

  // restoring division, quotient bits shift in where numerator bits leave
  assign rem_sh = {rem_q, q_q[NUM_BITS-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});
  assign diff   = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_BITS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      q_q   <= {q_q[NUM_BITS-2:0], ge};
      rem_q <= ge ? diff[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = q_q;

endmodule

@@ hdl/euler_mass_spring_step.sv @@
// channel   dir  handshake                    payload
// in        in   in_valid_i / in_stall_o      in_item_i  (ems_pkg::in_item_t)
// out       out  out_valid_o / out_stall_i    out_item_o (ems_pkg::out_item_t)
// cfg       in   cfg_we_i                     cfg_index_i, cfg_data_i
//
// load and set items are taken in the idle state; a step item works through the n
// springs in use (a spring with the mass on its anchor skips the divide and force)
// per spring cost is set by the bit-serial square root and divide
// reset restores config defaults and zeroes position and velocity, not the table
// a finished step waits in the output register; the next step stalls in its
// last cycle until the output register is free
module euler_mass_spring_step #(
  parameter int MAX_SPRINGS = ems_pkg::MAX_SPRINGS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  ems_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ems_pkg::out_item_t                out_item_o,
  input  logic                              cfg_we_i,
  input  logic [ems_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [ems_pkg::WORD_BITS-1:0]     cfg_data_i
);

  localparam int W   = ems_pkg::WORD_BITS;
  localparam int UW  = ems_pkg::UWORD_BITS;
  localparam int XW  = ems_pkg::EXT_BITS;
  localparam int AW  = $clog2(MAX_SPRINGS > 1 ? MAX_SPRINGS : 2);
  localparam int CW  = $clog2(MAX_SPRINGS + 1);
  localparam int SW  = $bits(ems_pkg::spring_t);
  localparam int NB  = ems_pkg::NUM_BITS;

  // configuration registers
  logic [ems_pkg::COUNT_BITS-1:0] spring_count_q;
  logic [UW-1:0]                  damping_q;
  logic signed [W-1:0]            gravity_q;
  logic [UW-1:0]                  time_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spring_count_q <= '0;
      damping_q      <= '0;
      gravity_q      <= '0;
      time_step_q    <= UW'(66);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ems_pkg::CFG_SPRING_COUNT: spring_count_q <= cfg_data_i[ems_pkg::COUNT_BITS-1:0];
        ems_pkg::CFG_DAMPING:      damping_q      <= cfg_data_i[UW-1:0];
        ems_pkg::CFG_GRAVITY:      gravity_q      <= cfg_data_i;
        ems_pkg::CFG_TIME_STEP:    time_step_q    <= cfg_data_i[UW-1:0];
        default: ;
      endcase
    end
  end

  ems_pkg::state_e state_q, state_d;

  logic accept;
  logic [CW-1:0] n_cfg;
  logic [CW-1:0] i_q, n_q;
  logic [1:0]    comp_q;
  logic          last_comp;

  logic signed [W-1:0] p_q   [3];
  logic signed [W-1:0] v_q   [3];
  logic signed [W-1:0] d_q   [3];
  logic signed [W-1:0] acc_q [3];
  logic signed [W-1:0] pn_q  [3];
  logic signed [W-1:0] vn_q  [3];
  logic signed [W-1:0] t_q, f_q;
  logic [UW-1:0]       rest_q, stiff_q;
  logic [XW-1:0]       s_q;
  logic                degen_q, clip_q;

  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [XW-1:0] mul_q;

  logic out_valid_q;
  ems_pkg::out_item_t out_q;
  logic out_free;

  // spring table in one synchronous memory
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  ems_pkg::spring_t ram_wdata, ram_rdata;
  logic [SW-1:0] ram_rbits;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ems_pkg::ST_IDLE);
  assign last_comp = (comp_q == 2'd2);
  assign out_free  = !out_valid_q || !out_stall_i;

  // spring_count above the table depth is clipped
  assign n_cfg = (int'(spring_count_q) > MAX_SPRINGS) ? CW'(MAX_SPRINGS)
                                                      : CW'(spring_count_q);

  assign ram_we    = accept && (in_item_i.opcode == ems_pkg::OP_LOAD) &&
                     (int'(in_item_i.spring_index) < MAX_SPRINGS);
  assign ram_waddr = AW'(in_item_i.spring_index);
  assign ram_raddr = AW'(i_q);
  assign ram_wdata = '{anchor_x:    in_item_i.vec_a_x,
                       anchor_y:    in_item_i.vec_a_y,
                       anchor_z:    in_item_i.vec_a_z,
                       rest_length: in_item_i.rest_length,
                       stiffness:   in_item_i.stiffness};
  assign ram_rdata = ems_pkg::spring_t'(ram_rbits);

  ems_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_SPRINGS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rbits)
  );

  // shared iterative units
  logic          sqrt_start, sqrt_busy;
  logic [W-1:0]  sqrt_root;
  logic          div_start, div_busy;
  logic [NB-1:0] div_quot;

  assign sqrt_start = (state_q == ems_pkg::ST_SQRT_START);
  assign div_start  = (state_q == ems_pkg::ST_LEN_CHECK) && (sqrt_root != '0);

  ems_isqrt #(
    .RAD_BITS (ems_pkg::RAD_BITS)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (s_q),
    .busy_o  (sqrt_busy),
    .root_o  (sqrt_root)
  );

  ems_div #(
    .NUM_BITS (NB),
    .DEN_BITS (W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({rest_q, {ems_pkg::FRAC_BITS{1'b0}}}),
    .den_i   (sqrt_root),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // saturating arithmetic around the one multiplier
  ems_pkg::sat_t fm_r, acc_add_r, acc_sub_r, grav_r, pos_r, vel_r, f_r;
  ems_pkg::sat_t dx_r [3];
  logic signed [XW-1:0] one_ext, ratio_ext;

  assign one_ext   = XW'(1) << ems_pkg::FRAC_BITS;
  assign ratio_ext = {{(XW-NB){1'b0}}, div_quot};

  always_comb begin
    fm_r      = ems_pkg::sat_word(mul_q >>> ems_pkg::FRAC_BITS);
    acc_add_r = ems_pkg::sat_word(ems_pkg::sext_word(acc_q[comp_q]) +
                                  ems_pkg::sext_word(fm_r.val));
    acc_sub_r = ems_pkg::sat_word(ems_pkg::sext_word(acc_q[comp_q]) -
                                  ems_pkg::sext_word(fm_r.val));
    grav_r    = ems_pkg::sat_word(ems_pkg::sext_word(acc_q[2]) -
                                  ems_pkg::sext_word(gravity_q));
    pos_r     = ems_pkg::sat_word(ems_pkg::sext_word(p_q[comp_q]) +
                                  ems_pkg::sext_word(fm_r.val));
    vel_r     = ems_pkg::sat_word(ems_pkg::sext_word(v_q[comp_q]) +
                                  ems_pkg::sext_word(fm_r.val));
    f_r       = ems_pkg::sat_word(one_ext - ratio_ext);
    dx_r[0]   = ems_pkg::sat_word(ems_pkg::sext_word(ram_rdata.anchor_x) -
                                  ems_pkg::sext_word(p_q[0]));
    dx_r[1]   = ems_pkg::sat_word(ems_pkg::sext_word(ram_rdata.anchor_y) -
                                  ems_pkg::sext_word(p_q[1]));
    dx_r[2]   = ems_pkg::sat_word(ems_pkg::sext_word(ram_rdata.anchor_z) -
                                  ems_pkg::sext_word(p_q[2]));
  end

  // multiplier operand select
  always_comb begin
    case (state_q)
      ems_pkg::ST_SQ_MUL: begin
        mul_a = d_q[comp_q];
        mul_b = d_q[comp_q];
      end
      ems_pkg::ST_TMUL: begin
        mul_a = d_q[comp_q];
        mul_b = {1'b0, stiff_q};
      end
      ems_pkg::ST_FMUL: begin
        mul_a = t_q;
        mul_b = f_q;
      end
      ems_pkg::ST_DAMP_MUL: begin
        mul_a = v_q[comp_q];
        mul_b = {1'b0, damping_q};
      end
      ems_pkg::ST_POS_MUL: begin
        mul_a = v_q[comp_q];
        mul_b = {1'b0, time_step_q};
      end
      ems_pkg::ST_VEL_MUL: begin
        mul_a = acc_q[comp_q];
        mul_b = {1'b0, time_step_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ems_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ems_pkg::ST_IDLE: begin
        if (accept && (in_item_i.opcode == ems_pkg::OP_STEP)) begin
          state_d = (n_cfg == '0) ? ems_pkg::ST_DAMP_MUL : ems_pkg::ST_RD;
        end
      end
      ems_pkg::ST_RD:         state_d = ems_pkg::ST_DIFF;
      ems_pkg::ST_DIFF:       state_d = ems_pkg::ST_SQ_MUL;
      ems_pkg::ST_SQ_MUL:     state_d = ems_pkg::ST_SQ_ADD;
      ems_pkg::ST_SQ_ADD:     state_d = last_comp ? ems_pkg::ST_SQRT_START
                                                  : ems_pkg::ST_SQ_MUL;
      ems_pkg::ST_SQRT_START: state_d = ems_pkg::ST_SQRT_WAIT;
      ems_pkg::ST_SQRT_WAIT: begin
        if (!sqrt_busy) begin
          state_d = ems_pkg::ST_LEN_CHECK;
        end
      end
      ems_pkg::ST_LEN_CHECK:  state_d = (sqrt_root == '0) ? ems_pkg::ST_NEXT
                                                          : ems_pkg::ST_DIV_WAIT;
      ems_pkg::ST_DIV_WAIT: begin
        if (!div_busy) begin
          state_d = ems_pkg::ST_FCALC;
        end
      end
      ems_pkg::ST_FCALC:      state_d = ems_pkg::ST_TMUL;
      ems_pkg::ST_TMUL:       state_d = ems_pkg::ST_TSAT;
      ems_pkg::ST_TSAT:       state_d = ems_pkg::ST_FMUL;
      ems_pkg::ST_FMUL:       state_d = ems_pkg::ST_ACC;
      ems_pkg::ST_ACC:        state_d = last_comp ? ems_pkg::ST_NEXT : ems_pkg::ST_TMUL;
      ems_pkg::ST_NEXT:       state_d = (i_q + CW'(1) == n_q) ? ems_pkg::ST_DAMP_MUL
                                                              : ems_pkg::ST_RD;
      ems_pkg::ST_DAMP_MUL:   state_d = ems_pkg::ST_DAMP_ACC;
      ems_pkg::ST_DAMP_ACC:   state_d = last_comp ? ems_pkg::ST_GRAV
                                                  : ems_pkg::ST_DAMP_MUL;
      ems_pkg::ST_GRAV:       state_d = ems_pkg::ST_POS_MUL;
      ems_pkg::ST_POS_MUL:    state_d = ems_pkg::ST_POS_ACC;
      ems_pkg::ST_POS_ACC:    state_d = last_comp ? ems_pkg::ST_VEL_MUL
                                                  : ems_pkg::ST_POS_MUL;
      ems_pkg::ST_VEL_MUL:    state_d = ems_pkg::ST_VEL_ACC;
      ems_pkg::ST_VEL_ACC:    state_d = last_comp ? ems_pkg::ST_FINISH
                                                  : ems_pkg::ST_VEL_MUL;
      ems_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = ems_pkg::ST_IDLE;
        end
      end
      default:                state_d = ems_pkg::ST_IDLE;
    endcase
  end

  // loop counters and mass state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      n_q    <= '0;
      comp_q <= '0;
      for (int k = 0; k < 3; k++) begin
        p_q[k] <= '0;
        v_q[k] <= '0;
      end
    end else begin
      case (state_q)
        ems_pkg::ST_IDLE: begin
          comp_q <= '0;
          if (accept && (in_item_i.opcode == ems_pkg::OP_SET)) begin
            p_q[0] <= in_item_i.vec_a_x;
            p_q[1] <= in_item_i.vec_a_y;
            p_q[2] <= in_item_i.vec_a_z;
            v_q[0] <= in_item_i.vec_b_x;
            v_q[1] <= in_item_i.vec_b_y;
            v_q[2] <= in_item_i.vec_b_z;
          end
          if (accept && (in_item_i.opcode == ems_pkg::OP_STEP)) begin
            i_q <= '0;
            n_q <= n_cfg;
          end
        end
        ems_pkg::ST_SQ_ADD, ems_pkg::ST_ACC, ems_pkg::ST_DAMP_ACC,
        ems_pkg::ST_POS_ACC, ems_pkg::ST_VEL_ACC: begin
          comp_q <= last_comp ? 2'd0 : comp_q + 2'd1;
        end
        ems_pkg::ST_LEN_CHECK: comp_q <= '0;
        ems_pkg::ST_NEXT: begin
          comp_q <= '0;
          i_q    <= i_q + CW'(1);
        end
        ems_pkg::ST_FINISH: begin
          if (out_free) begin
            for (int k = 0; k < 3; k++) begin
              p_q[k] <= pn_q[k];
              v_q[k] <= vn_q[k];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // step datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ems_pkg::ST_IDLE: begin
        degen_q <= 1'b0;
        clip_q  <= 1'b0;
        for (int k = 0; k < 3; k++) begin
          acc_q[k] <= '0;
        end
      end
      ems_pkg::ST_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          d_q[k] <= dx_r[k].val;
        end
        clip_q  <= clip_q | dx_r[0].clip | dx_r[1].clip | dx_r[2].clip;
        rest_q  <= ram_rdata.rest_length;
        stiff_q <= ram_rdata.stiffness;
        s_q     <= '0;
      end
      ems_pkg::ST_SQ_ADD: s_q <= s_q + XW'(unsigned'(mul_q));
      ems_pkg::ST_LEN_CHECK: begin
        // mass sits on the anchor: skip this spring
        if (sqrt_root == '0) begin
          degen_q <= 1'b1;
        end
      end
      ems_pkg::ST_FCALC: begin
        f_q    <= f_r.val;
        clip_q <= clip_q | f_r.clip;
      end
      ems_pkg::ST_TSAT: begin
        t_q    <= fm_r.val;
        clip_q <= clip_q | fm_r.clip;
      end
      ems_pkg::ST_ACC: begin
        acc_q[comp_q] <= acc_add_r.val;
        clip_q        <= clip_q | fm_r.clip | acc_add_r.clip;
      end
      ems_pkg::ST_DAMP_ACC: begin
        acc_q[comp_q] <= acc_sub_r.val;
        clip_q        <= clip_q | fm_r.clip | acc_sub_r.clip;
      end
      ems_pkg::ST_GRAV: begin
        acc_q[2] <= grav_r.val;
        clip_q   <= clip_q | grav_r.clip;
      end
      ems_pkg::ST_POS_ACC: begin
        pn_q[comp_q] <= pos_r.val;
        clip_q       <= clip_q | fm_r.clip | pos_r.clip;
      end
      ems_pkg::ST_VEL_ACC: begin
        vn_q[comp_q] <= vel_r.val;
        clip_q       <= clip_q | fm_r.clip | vel_r.clip;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ems_pkg::ST_FINISH) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ems_pkg::ST_FINISH) && out_free) begin
      out_q <= '{pos_x: pn_q[0], pos_y: pn_q[1], pos_z: pn_q[2],
                 vel_x: vn_q[0], vel_y: vn_q[1], vel_z: vn_q[2],
                 degenerate: degen_q, saturated: clip_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_sqrt_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_start |-> !sqrt_busy)
    else $error("square root started while busy");

  a_div_nonzero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (sqrt_root != '0) && !div_busy)
    else $error("divide started with zero length or while busy");

  a_spring_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ems_pkg::ST_RD) |-> (i_q < n_q))
    else $error("spring read beyond active count");

  a_finish_posts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ems_pkg::ST_FINISH) && out_free |=> out_valid_q)
    else $error("finished step did not reach output register");
`endif

endmodule
